// ----- design/assert_macros.svh -----
// Shared assertion helpers for the attitude filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is checked outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("attitude filter assertion failed");

// Condition that must never hold outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   `ASSERT_CLK(lbl, clk, rst, !(expr))

`endif

// ----- design/ica_pkg.sv -----
package ica_pkg;

   // Width of the CORDIC x/y datapath and of angles inside the block.
   localparam int CW = 38;
   localparam int ZW = 34;
   localparam int ACC_W = 66;

   typedef logic signed [CW-1:0] cdata_type;
   typedef logic signed [ZW-1:0] angle_type;

   // Angle constants in Q8.24.
   localparam angle_type PI_Q24 = 34'sd52707179;
   localparam angle_type HALF_PI_Q24 = 34'sd26353589;
   localparam angle_type TWO_PI_Q24 = 34'sd105414357;
   localparam angle_type FOUR_PI_Q24 = 34'sd210828714;
   localparam angle_type HALF_HEAD_BASE = 34'sd13170115;

   // CORDIC gain 0.607252935 in Q30.
   localparam cdata_type GAIN_Q30 = 38'sd652032874;

   // Sine and cosine of half the fixed roll, Q1.14.
   localparam logic signed [17:0] SIN_HALF_ROLL = -18'sd11581;
   localparam logic signed [17:0] COS_HALF_ROLL = 18'sd11590;

   // Configuration register indexes.
   localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
   localparam logic [1:0] REG_BLEND_WEIGHT = 2'd1;

   localparam logic [15:0] TICK_RESET = 16'd3277;
   localparam logic [16:0] BLEND_RESET = 17'd49152;
   localparam logic [16:0] BLEND_ONE = 17'd65536;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC,
      ST_VEC_ROLL,
      ST_MAG,
      ST_VEC_PITCH,
      ST_BLEND,
      ST_ROT,
      ST_QUAT,
      ST_OUT
   } state_type;

   // Command to the shared multiply-accumulate unit.
   typedef struct packed {
      logic en;
      logic accum;
      logic shift;
      logic signed [17:0] op_a;
      logic signed [32:0] op_b;
   } mac_cmd_type;

   // Command to the shared CORDIC unit.
   typedef struct packed {
      logic load;
      logic vectoring;
      cdata_type x;
      cdata_type y;
      angle_type z;
   } cordic_cmd_type;

   // Rounded atan(2^-i) in Q8.24.
   function automatic logic [23:0] atan_entry(input logic [4:0] idx);
      logic [23:0] v;
      case (idx)
         5'd0: v = 24'd13176795;
         5'd1: v = 24'd7778716;
         5'd2: v = 24'd4110060;
         5'd3: v = 24'd2086331;
         5'd4: v = 24'd1047214;
         5'd5: v = 24'd524117;
         5'd6: v = 24'd262123;
         5'd7: v = 24'd131069;
         5'd8: v = 24'd65536;
         5'd9: v = 24'd32768;
         5'd10: v = 24'd16384;
         5'd11: v = 24'd8192;
         5'd12: v = 24'd4096;
         5'd13: v = 24'd2048;
         5'd14: v = 24'd1024;
         5'd15: v = 24'd512;
         5'd16: v = 24'd256;
         5'd17: v = 24'd128;
         5'd18: v = 24'd64;
         5'd19: v = 24'd32;
         5'd20: v = 24'd16;
         5'd21: v = 24'd8;
         5'd22: v = 24'd4;
         5'd23: v = 24'd2;
         5'd24: v = 24'd1;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/imu_complementary_attitude.sv -----
// IMU attitude complementary filter.
// One item on the req_ channel is one timer tick with gyro rates and accelerometer counts.
// For each item exactly one result leaves on the rsp_ channel: filtered roll and pitch,
// wrapped yaw, a Q1.14 orientation quaternion and the gyro rates passed through.
// The block works on one item at a time. After acceptance the result is valid
// once three passes through the single CORDIC unit (one micro-rotation per
// cycle) and the multiply-accumulate steps on one shared multiplier are done.
// req_tready is high only while the block is idle; the next item can be taken
// in the cycle after the result is taken, so no new item is taken before the
// last result has been taken.
// If the receiver holds rsp_tready low, the result is held and no new item is taken.
// The csr_ channel writes tick_period (index 0) or blend_weight (index 1); other
// indexes are ignored. Write configuration only while the block is idle.
// Reset clears roll, pitch and yaw to zero and loads the default configuration.
module imu_complementary_attitude #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Fields from bit 0: gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z.
   input  logic [95:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: roll_out, pitch_out, yaw_out, quat_x, quat_y, quat_z,
   // quat_w, rate_x_out, rate_y_out, rate_z_out.
   output logic [207:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [16:0]  csr_data
);
   import ica_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] ph_ff, ph_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] gx_ff, gy_ff, gz_ff, ax_ff, ay_ff, az_ff;
   logic [15:0] tick_ff;
   logic [16:0] blend_ff;
   logic signed [31:0] roll_ff, roll_in;
   logic signed [31:0] pitch_ff, pitch_in;
   logic signed [31:0] yaw_ff, yaw_in;
   logic signed [31:0] rsum_ff, rsum_in;
   logic signed [31:0] psum_ff, psum_in;
   logic signed [31:0] acc_roll_ff, acc_roll_in;
   logic signed [31:0] acc_pitch_ff, acc_pitch_in;
   logic signed [15:0] q_ff [4];
   logic signed [15:0] q_in [4];

   mac_cmd_type mac_cmd;
   logic signed [ACC_W-1:0] mac_acc;
   cordic_cmd_type cor_cmd;
   cdata_type cor_x, cor_y;
   angle_type cor_z;
   logic cor_done;

   logic [16:0] alpha;
   logic [16:0] beta;
   logic signed [ZW-1:0] inc;
   logic signed [32:0] sum33;
   logic signed [31:0] sat_sum;
   logic signed [ZW-1:0] ywrap;
   logic signed [ACC_W-1:0] blend_res;
   cdata_type mag;
   logic signed [ACC_W-1:0] quat_res;
   logic signed [15:0] quat_val;
   angle_type hh;
   logic flip;
   logic signed [32:0] sin_v, cos_v;
   logic signed [32:0] sin_ff, sin_in, cos_ff, cos_in;
   logic signed [ZW-1:0] yaw_wide;

   ica_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .acc   (mac_acc)
   );

   ica_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_cmd),
      .x_out (cor_x),
      .y_out (cor_y),
      .z_out (cor_z),
      .done  (cor_done)
   );

   // Arithmetic shared by several sequencer steps.
   always_comb begin
      alpha = (blend_ff > BLEND_ONE) ? BLEND_ONE : blend_ff;
      beta = BLEND_ONE - alpha;
      inc = ($signed(mac_acc[ZW-1:0]) + 34'sd8) >>> 4;
      blend_res = (mac_acc + 66'sd32768) >>> 16;
      mag = CW'((mac_acc + (66'sd1 <<< 29)) >>> 30);
      quat_res = (mac_acc + (66'sd1 <<< 29)) >>> 30;
      if (quat_res > 66'sd16384) begin
         quat_val = 16'sd16384;
      end else if (quat_res < -66'sd16384) begin
         quat_val = -16'sd16384;
      end else begin
         quat_val = quat_res[15:0];
      end
      yaw_wide = ZW'(yaw_ff);
      // Half heading, brought into [-pi/2, pi/2] with a sign flip where needed.
      hh = HALF_HEAD_BASE - (yaw_wide >>> 1);
      if (hh >= PI_Q24) begin
         hh = hh - (PI_Q24 <<< 1);
      end
      if (hh < -PI_Q24) begin
         hh = hh + (PI_Q24 <<< 1);
      end
      flip = 1'b0;
      if (hh > HALF_PI_Q24) begin
         hh = hh - PI_Q24;
         flip = 1'b1;
      end else if (hh < -HALF_PI_Q24) begin
         hh = hh + PI_Q24;
         flip = 1'b1;
      end
      sin_v = flip ? -cor_y[32:0] : cor_y[32:0];
      cos_v = flip ? -cor_x[32:0] : cor_x[32:0];
   end

   // Sequencer: next state, datapath commands and register updates.
   always_comb begin
      state_in = state_ff;
      ph_in = ph_ff;
      rsp_valid_in = rsp_valid_ff;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      yaw_in = yaw_ff;
      rsum_in = rsum_ff;
      psum_in = psum_ff;
      acc_roll_in = acc_roll_ff;
      acc_pitch_in = acc_pitch_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      q_in = q_ff;
      mac_cmd = '0;
      cor_cmd = '0;
      sum33 = 33'(inc);
      sat_sum = '0;
      ywrap = '0;

      case (state_ff)
         ST_IDLE: begin
            ph_in = '0;
            if (req_tvalid) begin
               state_in = ST_INC;
            end
         end

         ST_INC: begin
            // Gyro times tick period for each axis, one product per cycle.
            mac_cmd.en = 1'b1;
            mac_cmd.op_a = 18'($signed({1'b0, tick_ff}));
            case (ph_ff)
               2'd0: mac_cmd.op_b = 33'(gx_ff);
               2'd1: mac_cmd.op_b = 33'(gy_ff);
               default: mac_cmd.op_b = 33'(gz_ff);
            endcase
            case (ph_ff)
               2'd1: sum33 = 33'(roll_ff) + 33'(inc);
               2'd2: sum33 = 33'(pitch_ff) + 33'(inc);
               default: sum33 = 33'(inc);
            endcase
            if (sum33 > 33'sd2147483647) begin
               sat_sum = 32'sh7fffffff;
            end else if (sum33 < -33'sd2147483648) begin
               sat_sum = 32'sh80000000;
            end else begin
               sat_sum = sum33[31:0];
            end
            ywrap = ZW'(yaw_ff) + inc + TWO_PI_Q24;
            if (ywrap < 0) begin
               ywrap = ywrap + FOUR_PI_Q24;
            end else if (ywrap >= FOUR_PI_Q24) begin
               ywrap = ywrap - FOUR_PI_Q24;
            end
            ywrap = ywrap - TWO_PI_Q24;
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd1: rsum_in = sat_sum;
               2'd2: psum_in = sat_sum;
               2'd3: begin
                  yaw_in = ywrap[31:0];
                  cor_cmd.load = 1'b1;
                  cor_cmd.vectoring = 1'b1;
                  cor_cmd.x = CW'(az_ff) <<< 16;
                  cor_cmd.y = CW'(ay_ff) <<< 16;
                  cor_cmd.z = '0;
                  state_in = ST_VEC_ROLL;
               end
               default: ;
            endcase
         end

         ST_VEC_ROLL: begin
            ph_in = '0;
            if (cor_done) begin
               // Accelerometer roll, then the low half of the magnitude times the gain.
               acc_roll_in = cor_z[31:0];
               mac_cmd.en = 1'b1;
               mac_cmd.op_a = 18'($signed({1'b0, cor_x[16:0]}));
               mac_cmd.op_b = 33'(GAIN_Q30);
               state_in = ST_MAG;
            end
         end

         ST_MAG: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd0) begin
               mac_cmd.en = 1'b1;
               mac_cmd.accum = 1'b1;
               mac_cmd.shift = 1'b1;
               mac_cmd.op_a = 18'($signed({1'b0, cor_x[33:17]}));
               mac_cmd.op_b = 33'(GAIN_Q30);
            end else begin
               cor_cmd.load = 1'b1;
               cor_cmd.vectoring = 1'b1;
               cor_cmd.x = mag;
               cor_cmd.y = -(CW'(ax_ff) <<< 16);
               cor_cmd.z = '0;
               state_in = ST_VEC_PITCH;
            end
         end

         ST_VEC_PITCH: begin
            ph_in = '0;
            if (cor_done) begin
               acc_pitch_in = cor_z[31:0];
               mac_cmd.en = 1'b1;
               mac_cmd.op_a = 18'($signed({1'b0, alpha}));
               mac_cmd.op_b = 33'(rsum_ff);
               state_in = ST_BLEND;
            end
         end

         ST_BLEND: begin
            // Weighted sums of gyro path and accelerometer angle, roll then pitch.
            mac_cmd.en = 1'b1;
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd0: begin
                  mac_cmd.accum = 1'b1;
                  mac_cmd.op_a = 18'($signed({1'b0, beta}));
                  mac_cmd.op_b = 33'(acc_roll_ff);
               end
               2'd1: begin
                  roll_in = blend_res[31:0];
                  mac_cmd.op_a = 18'($signed({1'b0, alpha}));
                  mac_cmd.op_b = 33'(psum_ff);
               end
               2'd2: begin
                  mac_cmd.accum = 1'b1;
                  mac_cmd.op_a = 18'($signed({1'b0, beta}));
                  mac_cmd.op_b = 33'(acc_pitch_ff);
               end
               default: begin
                  mac_cmd.en = 1'b0;
                  pitch_in = blend_res[31:0];
                  cor_cmd.load = 1'b1;
                  cor_cmd.vectoring = 1'b0;
                  cor_cmd.x = GAIN_Q30;
                  cor_cmd.y = '0;
                  cor_cmd.z = hh;
                  state_in = ST_ROT;
               end
            endcase
         end

         ST_ROT: begin
            ph_in = '0;
            if (cor_done) begin
               sin_in = sin_v;
               cos_in = cos_v;
               mac_cmd.en = 1'b1;
               mac_cmd.op_a = SIN_HALF_ROLL;
               mac_cmd.op_b = cos_v;
               state_in = ST_QUAT;
            end
         end

         ST_QUAT: begin
            // Quaternion components, one product per cycle.
            ph_in = ph_ff + 2'd1;
            q_in[ph_ff] = quat_val;
            mac_cmd.en = 1'b1;
            case (ph_ff)
               2'd0: begin
                  mac_cmd.op_a = SIN_HALF_ROLL;
                  mac_cmd.op_b = sin_ff;
               end
               2'd1: begin
                  mac_cmd.op_a = COS_HALF_ROLL;
                  mac_cmd.op_b = sin_ff;
               end
               2'd2: begin
                  mac_cmd.op_a = COS_HALF_ROLL;
                  mac_cmd.op_b = cos_ff;
               end
               default: begin
                  mac_cmd.en = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in = ST_OUT;
               end
            endcase
         end

         ST_OUT: begin
            ph_in = '0;
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control state and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff <= '0;
         rsp_valid_ff <= 1'b0;
         roll_ff <= '0;
         pitch_ff <= '0;
         yaw_ff <= '0;
         tick_ff <= TICK_RESET;
         blend_ff <= BLEND_RESET;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         roll_ff <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff <= yaw_in;
         if (csr_valid && csr_index == REG_TICK_PERIOD) begin
            tick_ff <= csr_data[15:0];
         end
         if (csr_valid && csr_index == REG_BLEND_WEIGHT) begin
            blend_ff <= csr_data;
         end
      end
   end

   // Item capture and working registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         gx_ff <= req_tdata[15:0];
         gy_ff <= req_tdata[31:16];
         gz_ff <= req_tdata[47:32];
         ax_ff <= req_tdata[63:48];
         ay_ff <= req_tdata[79:64];
         az_ff <= req_tdata[95:80];
      end
      rsum_ff <= rsum_in;
      psum_ff <= psum_in;
      acc_roll_ff <= acc_roll_in;
      acc_pitch_ff <= acc_pitch_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
      q_ff <= q_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {gz_ff, gy_ff, gx_ff, q_ff[3], q_ff[2], q_ff[1], q_ff[0],
                       yaw_ff, pitch_ff, roll_ff};

`include "assert_macros.svh"

   `ASSERT_NEVER(a_ready_while_valid, clock, reset, req_tready && rsp_tvalid)
   `ASSERT_CLK(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready)
   `ASSERT_CLK(a_valid_in_out_state, clock, reset, rsp_tvalid == (state_ff == ST_OUT))
   `ASSERT_CLK(a_yaw_range, clock, reset, (yaw_wide >= -TWO_PI_Q24) && (yaw_wide < TWO_PI_Q24))

endmodule

// ----- design/ica_mac.sv -----
module ica_mac (
   input  logic                      clock,
   input  ica_pkg::mac_cmd_type      cmd,
   output logic signed [ica_pkg::ACC_W-1:0] acc
);
   import ica_pkg::*;

   logic signed [50:0] prod;
   logic signed [ACC_W-1:0] term;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   // One signed product, optionally weighted by 2^17, added to or loaded into the accumulator.
   always_comb begin
      prod = cmd.op_a * cmd.op_b;
      term = ACC_W'(prod);
      if (cmd.shift) begin
         term = term <<< 17;
      end
      acc_in = cmd.accum ? acc_ff + term : term;
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- design/ica_cordic.sv -----
module ica_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ica_pkg::cordic_cmd_type cmd,
   output ica_pkg::cdata_type      x_out,
   output ica_pkg::cdata_type      y_out,
   output ica_pkg::angle_type      z_out,
   output logic                    done
);
   import ica_pkg::*;

   cdata_type x_ff, x_in;
   cdata_type y_ff, y_in;
   angle_type z_ff, z_in;
   logic vec_ff, vec_in;
   logic zero_ff, zero_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;

   cdata_type xs;
   cdata_type ys;
   angle_type step_angle;
   logic turn_pos;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      vec_in = vec_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in = cnt_ff;
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      step_angle = ZW'(atan_entry(cnt_ff));
      // Vectoring drives y to zero, rotation drives the residual angle to zero.
      turn_pos = vec_ff ? !y_ff[CW-1] : z_ff[ZW-1];

      if (cmd.load) begin
         // Vectoring with negative x starts a quarter turn away.
         x_in = cmd.x;
         y_in = cmd.y;
         z_in = cmd.z;
         if (cmd.vectoring && cmd.x[CW-1]) begin
            if (!cmd.y[CW-1]) begin
               x_in = cmd.y;
               y_in = -cmd.x;
               z_in = HALF_PI_Q24;
            end else begin
               x_in = -cmd.y;
               y_in = cmd.x;
               z_in = -HALF_PI_Q24;
            end
         end
         vec_in = cmd.vectoring;
         zero_in = cmd.vectoring && (cmd.x == '0) && (cmd.y == '0);
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in = '0;
      end else if (busy_ff) begin
         // One micro-rotation per cycle.
         if (turn_pos) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      vec_ff <= vec_in;
      zero_ff <= zero_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // A zero vector has angle zero and length zero.
   assign x_out = zero_ff ? '0 : x_ff;
   assign y_out = y_ff;
   assign z_out = zero_ff ? '0 : z_ff;
   assign done = done_ff;

endmodule
